@@ rtl/telemetry_frame_deframer_top_defines.svh @@
// Assertion macros shared by the telemetry frame deframer modules.
`ifndef TELEMETRY_FRAME_DEFRAMER_TOP_DEFINES_SVH
`define TELEMETRY_FRAME_DEFRAMER_TOP_DEFINES_SVH

// Checked on every clock edge outside reset.
`define TFD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("tfd assertion failed");

// Checked on every clock edge, reset included.
`define TFD_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("tfd assertion failed");

`endif

@@ rtl/tfd_pkg.sv @@
// Types, constants and helpers for the telemetry frame deframer.
package tfd_pkg;

  localparam int unsigned MaxFrameBytes = 256;
  localparam int unsigned CntW          = $clog2(MaxFrameBytes + 1);
  localparam int unsigned LenW          = 11;
  localparam int unsigned HeaderBytes   = 8;
  localparam int unsigned CrcBytes      = 2;
  localparam int unsigned QDepth        = 4;
  localparam int unsigned QPtrW         = $clog2(QDepth);
  localparam int unsigned QCntW         = $clog2(QDepth + 1);

  localparam logic [7:0] SyncA      = 8'hEB;
  localparam logic [7:0] SyncB      = 8'h90;
  localparam logic [3:0] MeterNib   = 4'h6;
  localparam logic [3:0] AnalogMax  = 4'h3;

  typedef enum logic {
    CMD_BYTE    = 1'b0,
    CMD_TIMEOUT = 1'b1
  } tfd_cmd_e;

  typedef enum logic [1:0] {
    EV_POINT = 2'd0,
    EV_DONE  = 2'd1,
    EV_ABORT = 2'd2
  } tfd_event_e;

  typedef enum logic [1:0] {
    KIND_ANALOG = 2'd0,
    KIND_STATUS = 2'd1,
    KIND_METER  = 2'd2
  } tfd_kind_e;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } tfd_in_t;

  typedef struct packed {
    logic [1:0]         event_res;
    logic [1:0]         kind;
    logic [6:0]         point_index;
    logic signed [31:0] value;
    logic [4:0]         station;
    logic [7:0]         function_code;
    logic               last;
  } tfd_out_t;

  // One queued unit of work: up to eight points followed by an optional
  // frame-complete or abort result.
  typedef struct packed {
    tfd_kind_e   kind;
    logic [4:0]  station;
    logic [7:0]  function_code;
    logic [3:0]  npts;
    logic [6:0]  base_index;
    logic [31:0] value;
    logic        has_term;
    tfd_event_e  term_ev;
  } tfd_job_t;

  function automatic tfd_kind_e frame_kind(input logic [7:0] fn);
    tfd_kind_e k;
    if (fn[7:4] == MeterNib) begin
      k = KIND_METER;
    end else if (fn[3:0] <= AnalogMax) begin
      k = KIND_ANALOG;
    end else begin
      k = KIND_STATUS;
    end
    return k;
  endfunction

endpackage

@@ rtl/tfd_front.sv @@
// Front end: sync hunt, header parse and payload byte classification.
`include "telemetry_frame_deframer_top_defines.svh"

module tfd_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  tfd_pkg::tfd_in_t in_item_i,
  output logic             push_o,
  input  logic             q_full_i,
  output tfd_pkg::tfd_job_t job_o
);

  logic                     accept;
  logic [2:0]               pos_q, pos_d;
  logic                     coll_q, coll_d;
  logic [tfd_pkg::CntW-1:0] p_q, p_d;
  logic [tfd_pkg::CntW-1:0] dlen_q, dlen_d;
  logic [7:0]               fn_q, fn_d;
  logic [6:0]               info_q, info_d;
  logic [4:0]               stn_q, stn_d;
  logic [23:0]              asm_q, asm_d;
  logic [6:0]               pc_q, pc_d;

  tfd_pkg::tfd_kind_e       kind;
  logic [7:0]               b;
  logic [7:0]               want;
  logic [tfd_pkg::LenW-1:0] new_dlen;
  logic [tfd_pkg::LenW-1:0] total;
  logic [6:0]               new_info;
  logic [15:0]              raw16;
  logic [6:0]               base8;
  logic [6:0]               rem;
  logic [tfd_pkg::CntW:0]   p_next;
  logic [tfd_pkg::CntW:0]   end_cnt;

  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign kind       = tfd_pkg::frame_kind(fn_q);
  assign b          = in_item_i.rx_byte;
  assign want       = pos_q[0] ? tfd_pkg::SyncB : tfd_pkg::SyncA;
  assign new_info   = b[6:0];
  assign raw16      = {b, asm_q[7:0]};
  assign base8      = {p_q[3:0], 3'b000};
  assign rem        = info_q - base8;
  assign p_next     = {1'b0, p_q} + 1'b1;
  assign end_cnt    = {1'b0, dlen_q} + (tfd_pkg::CntW + 1)'(tfd_pkg::CrcBytes);

  always_comb begin
    unique case (tfd_pkg::frame_kind(fn_q))
      tfd_pkg::KIND_METER:  new_dlen = {2'b00, new_info, 2'b00};
      tfd_pkg::KIND_ANALOG: new_dlen = {3'b000, new_info, 1'b0};
      default:              new_dlen = tfd_pkg::LenW'(({1'b0, new_info} + 8'd7) >> 3);
    endcase
    total = new_dlen + tfd_pkg::LenW'(tfd_pkg::HeaderBytes + tfd_pkg::CrcBytes);
  end

  always_comb begin
    pos_d  = pos_q;
    coll_d = coll_q;
    p_d    = p_q;
    dlen_d = dlen_q;
    fn_d   = fn_q;
    info_d = info_q;
    stn_d  = stn_q;
    asm_d  = asm_q;
    pc_d   = pc_q;
    push_o = 1'b0;

    job_o.kind          = kind;
    job_o.station       = stn_q;
    job_o.function_code = fn_q;
    job_o.npts          = 4'd0;
    job_o.base_index    = pc_q;
    job_o.value         = 32'd0;
    job_o.has_term      = 1'b0;
    job_o.term_ev       = tfd_pkg::EV_DONE;

    if (accept) begin
      if (in_item_i.cmd == tfd_pkg::CMD_TIMEOUT) begin
        if (coll_q) begin
          push_o         = 1'b1;
          job_o.has_term = 1'b1;
          job_o.term_ev  = tfd_pkg::EV_ABORT;
          pos_d          = 3'd0;
          coll_d         = 1'b0;
          p_d            = '0;
          asm_d          = 24'd0;
          pc_d           = 7'd0;
        end
      end else if (!coll_q) begin
        if (pos_q < 3'd6) begin
          if (b == want) begin
            pos_d = pos_q + 3'd1;
          end else if (pos_q[0] && b == tfd_pkg::SyncA) begin
            pos_d = 3'd1;
          end else begin
            pos_d = 3'd0;
          end
        end else if (pos_q == 3'd6) begin
          fn_d  = b;
          pos_d = 3'd7;
        end else begin
          info_d = new_info;
          stn_d  = b[7] ? b[7:3] : 5'd1;
          pos_d  = 3'd0;
          asm_d  = 24'd0;
          pc_d   = 7'd0;
          p_d    = '0;
          // Oversize frames are dropped and the hunt starts over.
          if (total <= tfd_pkg::LenW'(tfd_pkg::MaxFrameBytes)) begin
            coll_d = 1'b1;
            dlen_d = new_dlen[tfd_pkg::CntW-1:0];
          end
        end
      end else begin
        p_d = p_next[tfd_pkg::CntW-1:0];
        if (p_q < dlen_q) begin
          unique case (kind)
            tfd_pkg::KIND_ANALOG: begin
              if (!p_q[0]) begin
                asm_d = {16'd0, b};
              end else begin
                push_o      = 1'b1;
                job_o.npts  = 4'd1;
                job_o.value = {{16{raw16[15]}}, raw16};
                pc_d        = pc_q + 7'd1;
              end
            end
            tfd_pkg::KIND_METER: begin
              unique case (p_q[1:0])
                2'd0: asm_d = {16'd0, b};
                2'd1: asm_d[15:8] = b;
                2'd2: asm_d[23:16] = b;
                default: begin
                  push_o      = 1'b1;
                  job_o.npts  = 4'd1;
                  job_o.value = {b, asm_q};
                  pc_d        = pc_q + 7'd1;
                end
              endcase
            end
            default: begin
              // Status bytes never reach past 16 payload bytes.
              push_o           = 1'b1;
              job_o.npts       = (rem >= 7'd8) ? 4'd8 : rem[3:0];
              job_o.base_index = base8;
              job_o.value      = {24'd0, b};
              pc_d             = pc_q + 7'd8;
            end
          endcase
        end
        if (p_next == end_cnt) begin
          push_o         = 1'b1;
          job_o.has_term = 1'b1;
          job_o.term_ev  = tfd_pkg::EV_DONE;
          pos_d          = 3'd0;
          coll_d         = 1'b0;
          p_d            = '0;
          asm_d          = 24'd0;
          pc_d           = 7'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 3'd0;
      coll_q <= 1'b0;
      p_q    <= '0;
      dlen_q <= '0;
      fn_q   <= 8'd0;
      info_q <= 7'd0;
      stn_q  <= 5'd1;
      asm_q  <= 24'd0;
      pc_q   <= 7'd0;
    end else begin
      pos_q  <= pos_d;
      coll_q <= coll_d;
      p_q    <= p_d;
      dlen_q <= dlen_d;
      fn_q   <= fn_d;
      info_q <= info_d;
      stn_q  <= stn_d;
      asm_q  <= asm_d;
      pc_q   <= pc_d;
    end
  end

  `TFD_ASSERT(a_push_has_work, push_o |-> (job_o.npts != 4'd0 || job_o.has_term))
  `TFD_ASSERT(a_hunt_pos_clear, !coll_q |-> (p_q == '0))
  `TFD_ASSERT(a_coll_within_frame, coll_q |-> (p_q <= dlen_q + tfd_pkg::CntW'(1)))

endmodule

@@ rtl/tfd_queue.sv @@
// Short job queue between the front end and the result expander.
`include "telemetry_frame_deframer_top_defines.svh"

module tfd_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  tfd_pkg::tfd_job_t push_job_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output tfd_pkg::tfd_job_t head_job_o
);

  tfd_pkg::tfd_job_t         mem_q [tfd_pkg::QDepth];
  logic [tfd_pkg::QPtrW-1:0] wr_q, wr_d;
  logic [tfd_pkg::QPtrW-1:0] rd_q, rd_d;
  logic [tfd_pkg::QCntW-1:0] cnt_q, cnt_d;

  assign full_o       = (cnt_q == tfd_pkg::QCntW'(tfd_pkg::QDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_job_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  `TFD_ASSERT(a_no_overflow, !(push_i && full_o))
  `TFD_ASSERT(a_no_underflow, pop_i |-> head_valid_o)
  `TFD_ASSERT(a_cnt_in_range, cnt_q <= tfd_pkg::QCntW'(tfd_pkg::QDepth))

endmodule

@@ rtl/tfd_back.sv @@
// Back end: expands queued jobs into result items through an output register.
`include "telemetry_frame_deframer_top_defines.svh"

module tfd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  tfd_pkg::tfd_job_t head_job_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tfd_pkg::tfd_out_t out_item_o
);

  logic                 out_valid_q, out_valid_d;
  tfd_pkg::tfd_out_t    out_q, res;
  logic [3:0]           step_q, step_d;
  logic [3:0]           total;
  logic                 last_step;
  logic                 load;
  logic                 is_point;

  assign total     = head_job_i.npts + {3'b000, head_job_i.has_term};
  assign last_step = (step_q + 4'd1 == total);
  assign load      = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o     = load && last_step;
  assign is_point  = (step_q < head_job_i.npts);

  always_comb begin
    res.kind          = head_job_i.kind;
    res.station       = head_job_i.station;
    res.function_code = head_job_i.function_code;
    res.last          = last_step;
    if (is_point) begin
      res.event_res   = tfd_pkg::EV_POINT;
      res.point_index = head_job_i.base_index + {3'b000, step_q};
      if (head_job_i.kind == tfd_pkg::KIND_STATUS) begin
        res.value = {31'd0, head_job_i.value[step_q[2:0]]};
      end else begin
        res.value = head_job_i.value;
      end
    end else begin
      res.event_res   = head_job_i.term_ev;
      res.point_index = 7'd0;
      res.value       = 32'sd0;
    end
  end

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (load) begin
      step_d      = last_step ? 4'd0 : step_q + 4'd1;
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= 4'd0;
    end else begin
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `TFD_ASSERT(a_abort_is_last,
    (out_valid_o && out_item_o.event_res == tfd_pkg::EV_ABORT) |-> out_item_o.last)
  `TFD_ASSERT_ALWAYS(a_step_idle, (!head_valid_i && rst_ni) |-> (step_q == 4'd0))
  `TFD_ASSERT(a_out_hold, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))

endmodule

@@ rtl/telemetry_frame_deframer_top.sv @@
// Top level of the telemetry frame deframer.
// Accepts one received byte or timeout item per cycle while the four-entry
// job queue has room; the front end parses the sync header and payload in
// that same cycle. Results leave through a registered output stage, one per
// cycle while the output is not stalled: a payload byte that completes an
// analog or meter point yields one result, a status byte yields up to eight
// (one per bit), and the last CRC byte or a timeout inside a frame yields one
// frame-complete or abort result, so sustained throughput is set by the
// result expander. Frames whose length exceeds 256 bytes are dropped
// silently, and the CRC is counted but not checked.
module telemetry_frame_deframer_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  tfd_pkg::tfd_in_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output tfd_pkg::tfd_out_t out_item_o
);

  logic              push;
  logic              q_full;
  logic              pop;
  logic              head_valid;
  tfd_pkg::tfd_job_t push_job;
  tfd_pkg::tfd_job_t head_job;

  tfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .push_o     (push),
    .q_full_i   (q_full),
    .job_o      (push_job)
  );

  tfd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_job_o   (head_job)
  );

  tfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_job_i   (head_job),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule

@@ tb/sv/testbench.sv @@
// Self-checking testbench for the telemetry frame deframer top level.
`timescale 1ns / 100ps

module testbench;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  tfd_pkg::tfd_in_t  in_item_i;
  logic              out_valid_o;
  logic              out_stall_i;
  tfd_pkg::tfd_out_t out_item_o;

  telemetry_frame_deframer_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  // Deframer state as this testbench tracks it.
  logic [8:0]  hdr_count;
  logic        in_frame;
  logic [8:0]  frame_len;
  logic [7:0]  fn_byte;
  logic [6:0]  n_points;
  logic [4:0]  stn_id;
  logic [23:0] partial_value;
  logic [6:0]  pt_ctr;

  tfd_pkg::tfd_out_t item_results[$];
  tfd_pkg::tfd_out_t pending_results[$];
  int                items_sent;
  int                error_count;
  bit                no_idle;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("telemetry_frame_deframer_top: mismatch");
    $finish;
  end

  task automatic go_hunt();
    hdr_count     = '0;
    in_frame      = 1'b0;
    partial_value = '0;
    pt_ctr        = '0;
  endtask

  task automatic add_result(input tfd_pkg::tfd_event_e ev, input logic [6:0] idx,
                            input logic [31:0] val, input tfd_pkg::tfd_kind_e k);
    tfd_pkg::tfd_out_t r;
    r.event_res     = ev;
    r.kind          = k;
    r.point_index   = idx;
    r.value         = val;
    r.station       = stn_id;
    r.function_code = fn_byte;
    r.last          = 1'b0;
    item_results.insert(item_results.size(), r);
  endtask

  // Works out the results that one accepted item causes.
  task automatic decode_item(input tfd_pkg::tfd_in_t it);
    tfd_pkg::tfd_kind_e k;
    logic [7:0]         b;
    logic [31:0]        raw;
    int                 p;
    int                 dlen;
    int                 total;
    int                 i;
    item_results = {};
    b = it.rx_byte;
    if (fn_byte[7:4] == tfd_pkg::MeterNib) begin
      k = tfd_pkg::KIND_METER;
    end else if (fn_byte[3:0] <= tfd_pkg::AnalogMax) begin
      k = tfd_pkg::KIND_ANALOG;
    end else begin
      k = tfd_pkg::KIND_STATUS;
    end
    if (it.cmd == tfd_pkg::CMD_TIMEOUT) begin
      // A quiet line only matters once a frame is being collected.
      if (in_frame) begin
        add_result(tfd_pkg::EV_ABORT, '0, '0, k);
        go_hunt();
      end
    end else if (!in_frame) begin
      if (hdr_count < 6) begin
        if (b == (hdr_count[0] ? tfd_pkg::SyncB : tfd_pkg::SyncA)) begin
          hdr_count = hdr_count + 9'd1;
        end else if (hdr_count[0] && b == tfd_pkg::SyncA) begin
          hdr_count = 9'd1;
        end else begin
          hdr_count = '0;
        end
      end else if (hdr_count == 6) begin
        fn_byte   = b;
        hdr_count = 9'd7;
      end else begin
        n_points = b[6:0];
        stn_id   = b[7] ? b[7:3] : 5'd1;
        if (k == tfd_pkg::KIND_METER) begin
          dlen = n_points * 4;
        end else if (k == tfd_pkg::KIND_ANALOG) begin
          dlen = n_points * 2;
        end else begin
          dlen = (n_points + 7) / 8;
        end
        total = tfd_pkg::HeaderBytes + dlen + tfd_pkg::CrcBytes;
        if (total > tfd_pkg::MaxFrameBytes) begin
          go_hunt();
        end else begin
          frame_len     = 9'(total);
          in_frame      = 1'b1;
          hdr_count     = 9'(tfd_pkg::HeaderBytes);
          partial_value = '0;
          pt_ctr        = '0;
        end
      end
    end else begin
      p    = hdr_count - tfd_pkg::HeaderBytes;
      dlen = frame_len - tfd_pkg::HeaderBytes - tfd_pkg::CrcBytes;
      hdr_count = hdr_count + 9'd1;
      if (p < dlen) begin
        case (k)
          tfd_pkg::KIND_ANALOG: begin
            if (p[0] == 1'b0) begin
              partial_value = {16'd0, b};
            end else begin
              raw = {{16{b[7]}}, b, partial_value[7:0]};
              add_result(tfd_pkg::EV_POINT, pt_ctr, raw, k);
              pt_ctr = pt_ctr + 7'd1;
            end
          end
          tfd_pkg::KIND_METER: begin
            case (p[1:0])
              2'd0: partial_value = {16'd0, b};
              2'd1: partial_value[15:8] = b;
              2'd2: partial_value[23:16] = b;
              default: begin
                raw = {b, partial_value};
                add_result(tfd_pkg::EV_POINT, pt_ctr, raw, k);
                pt_ctr = pt_ctr + 7'd1;
              end
            endcase
          end
          default: begin
            // Bits past the point count in the last byte are padding.
            for (i = 0; i < 8; i++) begin
              if (p * 8 + i < n_points) begin
                add_result(tfd_pkg::EV_POINT, 7'(p * 8 + i), {31'd0, b[i]}, k);
              end
            end
            pt_ctr = pt_ctr + 7'd8;
          end
        endcase
      end
      if (hdr_count >= frame_len) begin
        add_result(tfd_pkg::EV_DONE, '0, '0, k);
        go_hunt();
      end
    end
    if (item_results.size() > 0) begin
      item_results[item_results.size() - 1].last = 1'b1;
    end
    foreach (item_results[j]) begin
      pending_results.insert(pending_results.size(), item_results[j]);
    end
  endtask

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input tfd_pkg::tfd_cmd_e c, input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{cmd: c, rx_byte: b};
    do @(posedge clk_i); while (in_stall_o);
    decode_item(in_item_i);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_bytes(input logic [7:0] seq[$]);
    foreach (seq[i]) begin
      send_item(tfd_pkg::CMD_BYTE, seq[i]);
    end
  endtask

  task automatic send_header(input logic [7:0] fn, input logic [7:0] count_byte);
    repeat (3) begin
      send_item(tfd_pkg::CMD_BYTE, tfd_pkg::SyncA);
      send_item(tfd_pkg::CMD_BYTE, tfd_pkg::SyncB);
    end
    send_item(tfd_pkg::CMD_BYTE, fn);
    send_item(tfd_pkg::CMD_BYTE, count_byte);
  endtask

  // Holds the sender off until every predicted result has come out.
  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_results.size() != 0) @(negedge clk_i);
  endtask

  // Quiet line while hunting and inside the header, then a meter frame with
  // the extreme 32-bit values and a station taken from the count byte.
  task automatic test_meter_points();
    send_item(tfd_pkg::CMD_TIMEOUT, 8'hFF);
    send_bytes('{tfd_pkg::SyncA, tfd_pkg::SyncB, tfd_pkg::SyncA});
    send_item(tfd_pkg::CMD_TIMEOUT, 8'h00);
    send_bytes('{tfd_pkg::SyncB, tfd_pkg::SyncA, tfd_pkg::SyncB, 8'h6F, 8'h82});
    send_bytes('{8'h00, 8'h00, 8'h00, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'h7F});
    send_bytes('{8'h00, 8'hFF});
    wait_for_results();
  endtask

  // Header restarts: a 0xEB where 0x90 is due, any other mismatch, and a
  // leading 0x90; then an empty analog frame.
  task automatic test_sync_hunt();
    send_bytes('{tfd_pkg::SyncA, tfd_pkg::SyncB, 8'h00, tfd_pkg::SyncB,
                 tfd_pkg::SyncA, tfd_pkg::SyncA});
    send_bytes('{tfd_pkg::SyncB, tfd_pkg::SyncA, tfd_pkg::SyncB, tfd_pkg::SyncA,
                 tfd_pkg::SyncB, 8'h03, 8'h00, 8'h12, 8'h34});
    wait_for_results();
  endtask

  // Oversize analog and meter frames are dropped; the largest analog frame
  // that fits is taken and then cut short by a quiet line.
  task automatic test_size_limits();
    send_header(8'h00, 8'hFC);
    send_header(8'h6A, 8'h3E);
    send_header(8'h01, 8'hFB);
    send_bytes('{8'h00, 8'h80, 8'hFF, 8'h7F});
    send_item(tfd_pkg::CMD_TIMEOUT, 8'h5A);
    wait_for_results();
  endtask

  // Status bits with a partial last byte and an abort during the CRC, then
  // a full byte of status bits.
  task automatic test_status_bits();
    send_header(8'h14, 8'h8B);
    send_bytes('{8'hA5, 8'hFF, 8'hAA});
    send_item(tfd_pkg::CMD_TIMEOUT, 8'h00);
    send_header(8'hF4, 8'h08);
    send_bytes('{8'h5A, 8'h01, 8'h02});
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    int                target;
    int                dlen;
    int                body;
    int                cut;
    int                i;
    logic [3:0]        hi;
    logic [7:0]        fn;
    logic [6:0]        npt;
    tfd_pkg::tfd_cmd_e c;
    target = 250;
    while (items_sent < target) begin
      no_idle = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 9))
        0: begin
          repeat ($urandom_range(1, 3)) begin
            c = ($urandom_range(0, 5) == 0) ? tfd_pkg::CMD_TIMEOUT : tfd_pkg::CMD_BYTE;
            send_item(c, 8'($urandom_range(0, 255)));
          end
        end
        1: begin
          // Broken header: a correct prefix, then any byte at all.
          for (i = 0; i < $urandom_range(1, 5); i++) begin
            send_item(tfd_pkg::CMD_BYTE, i[0] ? tfd_pkg::SyncB : tfd_pkg::SyncA);
          end
          send_item(tfd_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
        end
        default: begin
          hi = 4'($urandom_range(0, 15));
          if (hi == tfd_pkg::MeterNib) hi = 4'h7;
          case ($urandom_range(0, 3))
            0: fn = {tfd_pkg::MeterNib, 4'($urandom_range(0, 15))};
            1: fn = {hi, 4'($urandom_range(0, 3))};
            2: fn = {hi, 4'($urandom_range(4, 15))};
            default: fn = 8'($urandom_range(0, 255));
          endcase
          if (fn[7:4] == tfd_pkg::MeterNib) begin
            npt  = ($urandom_range(0, 11) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(0, 6));
            dlen = npt * 4;
          end else if (fn[3:0] <= tfd_pkg::AnalogMax) begin
            npt  = ($urandom_range(0, 11) == 0) ? 7'($urandom_range(0, 127))
                                                : 7'($urandom_range(0, 6));
            dlen = npt * 2;
          end else begin
            npt  = 7'($urandom_range(0, 127));
            dlen = (npt + 7) / 8;
          end
          send_header(fn, {1'($urandom_range(0, 1)), npt});
          body = dlen + 2;
          if (body + 8 <= 256) begin
            cut = -1;
            if (body > 24 || $urandom_range(0, 7) == 0) begin
              cut = $urandom_range(0, (body > 12) ? 12 : body - 1);
            end
            for (i = 0; i < body; i++) begin
              if (i == cut) begin
                send_item(tfd_pkg::CMD_TIMEOUT, 8'($urandom_range(0, 255)));
                break;
              end
              send_item(tfd_pkg::CMD_BYTE, 8'($urandom_range(0, 255)));
            end
          end
        end
      endcase
      if ($urandom_range(0, 15) == 0) wait_for_results();
    end
    no_idle = 1'b0;
  endtask

  initial begin : result_checker
    tfd_pkg::tfd_out_t got;
    tfd_pkg::tfd_out_t want;
    int                hold;
    bit                bad;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 19);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      got = out_item_o;
      if (pending_results.size() == 0) begin
        $error("unexpected result item %p", got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        bad  = 1'b0;
        if (got.event_res !== want.event_res) begin
          $error("event_res: expected %0d, actual %0d", want.event_res, got.event_res);
          bad = 1'b1;
        end
        if (got.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, got.kind);
          bad = 1'b1;
        end
        if (got.point_index !== want.point_index) begin
          $error("point_index: expected %0d, actual %0d", want.point_index,
                 got.point_index);
          bad = 1'b1;
        end
        if (got.value !== want.value) begin
          $error("value: expected %h, actual %h", want.value, got.value);
          bad = 1'b1;
        end
        if (got.station !== want.station) begin
          $error("station: expected %0d, actual %0d", want.station, got.station);
          bad = 1'b1;
        end
        if (got.function_code !== want.function_code) begin
          $error("function_code: expected %h, actual %h", want.function_code,
                 got.function_code);
          bad = 1'b1;
        end
        if (got.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, got.last);
          bad = 1'b1;
        end
        if (bad) error_count++;
      end
      @(negedge clk_i);
    end
  end

  initial begin : stimulus
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_item_i   = '0;
    out_stall_i = 1'b1;
    no_idle     = 1'b0;
    items_sent  = 0;
    error_count = 0;
    go_hunt();
    frame_len = '0;
    fn_byte   = '0;
    n_points  = '0;
    stn_id    = 5'd1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_meter_points();
    test_sync_hunt();
    test_size_limits();
    test_status_bits();
    test_random_traffic();
    wait_for_results();
    repeat (40) @(negedge clk_i);
    if (error_count == 0) begin
      $display("telemetry_frame_deframer_top: match");
    end else begin
      $display("telemetry_frame_deframer_top: mismatch");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/tfd_pkg.sv
rtl/tfd_front.sv
rtl/tfd_queue.sv
rtl/tfd_back.sv
rtl/telemetry_frame_deframer_top.sv
tb/sv/testbench.sv
